// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the state-space filter.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define SSF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SSF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ssf_pkg.sv
// Package for the state-space filter: register map codes and fixed widths.
// No dependencies.
package ssf_pkg;

   localparam int COEF_W   = 16;   // Q2.13 coefficient
   localparam int STATE_W  = 32;   // saturated state value
   localparam int SAMPLE_W = 16;   // input and output samples
   localparam int FRAC_W   = 13;   // fraction bits dropped after each sum
   localparam int CSR_DW   = 64;
   localparam int CSR_AW   = 6;    // 8-byte registers, seven of them
   localparam int NUM_COEF = 4;    // coefficients packed in one register

   typedef enum logic [2:0] {
      REG_A_ROW_ZERO  = 3'd0,
      REG_A_ROW_ONE   = 3'd1,
      REG_A_ROW_TWO   = 3'd2,
      REG_A_ROW_THREE = 3'd3,
      REG_B_COLUMN    = 3'd4,
      REG_C_ROW       = 3'd5,
      REG_D_GAIN      = 3'd6
   } reg_index_type;

   typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_vec_type;

endpackage

// File: rtl/state_space_filter_step.sv
// State-space filter, single input and output, up to four states.
// Depends on ssf_pkg and assert_macros.svh.
//
//   channel  direction  handshake             payload
//   req      in         req_valid / req_stall req_sample_in (s16)
//   rsp      out        rsp_valid / rsp_stall rsp_sample_out (s16), rsp_clipped
//   csr      in         psel/penable/pready   paddr, pwdata, prdata (64 bit)
//
// One request per cycle while req_stall is low: input register, then the
// whole y = C.x + D.u and x <- A.x + B.u in one pass into the result
// register. The state recurrence closes in that single pass, so the depth
// of the multiply and five-term add sets the clock.
// Reset (synchronous) clears the state, coefficients and both valid flags.
// A stalled result holds; the input register keeps filling behind it
// until it too is full, and only then is req_stall raised.
`include "assert_macros.svh"

module state_space_filter_step #(
   parameter int STATE_ORDER = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ssf_pkg::SAMPLE_W-1:0] req_sample_in,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ssf_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                rsp_clipped,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic        [ssf_pkg::CSR_AW-1:0]   paddr,
   input  logic        [ssf_pkg::CSR_DW-1:0]   pwdata,
   output logic        [ssf_pkg::CSR_DW-1:0]   prdata,
   output logic                                pready
);

   // Products are 48 bits; five of them fit comfortably in 52.
   localparam int PROD_W = ssf_pkg::COEF_W + ssf_pkg::STATE_W;
   localparam int ACC_W  = PROD_W + 4;
   localparam int RND_W  = ACC_W - ssf_pkg::FRAC_W;
   localparam int REG_SEL_LO = 3;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (ssf_pkg::FRAC_W - 1);
   localparam logic signed [RND_W-1:0] OUT_MAX = RND_W'(32767);
   localparam logic signed [RND_W-1:0] OUT_MIN = -RND_W'(32768);
   localparam logic signed [RND_W-1:0] ST_MAX  = RND_W'(64'sd2147483647);
   localparam logic signed [RND_W-1:0] ST_MIN  = -RND_W'(64'sd2147483648);

   // ---------------------------------------------------------------------
   // Coefficient registers
   // ---------------------------------------------------------------------
   ssf_pkg::coef_vec_type                  a_coef_ff [4];
   ssf_pkg::coef_vec_type                  b_coef_ff;
   ssf_pkg::coef_vec_type                  c_coef_ff;
   logic        [ssf_pkg::COEF_W-1:0]      d_gain_ff;

   ssf_pkg::reg_index_type                 reg_sel;
   logic                                   csr_write;

   assign reg_sel   = ssf_pkg::reg_index_type'(paddr[ssf_pkg::CSR_AW-1:REG_SEL_LO]);
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            a_coef_ff[i] <= '0;
         end
         b_coef_ff <= '0;
         c_coef_ff <= '0;
         d_gain_ff <= '0;
      end else if (csr_write) begin
         case (reg_sel)
            ssf_pkg::REG_A_ROW_ZERO:  a_coef_ff[0] <= pwdata;
            ssf_pkg::REG_A_ROW_ONE:   a_coef_ff[1] <= pwdata;
            ssf_pkg::REG_A_ROW_TWO:   a_coef_ff[2] <= pwdata;
            ssf_pkg::REG_A_ROW_THREE: a_coef_ff[3] <= pwdata;
            ssf_pkg::REG_B_COLUMN:    b_coef_ff    <= pwdata;
            ssf_pkg::REG_C_ROW:       c_coef_ff    <= pwdata;
            ssf_pkg::REG_D_GAIN:      d_gain_ff    <= pwdata[ssf_pkg::COEF_W-1:0];
            default: ;   // unmapped: write dropped
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         ssf_pkg::REG_A_ROW_ZERO:  prdata = a_coef_ff[0];
         ssf_pkg::REG_A_ROW_ONE:   prdata = a_coef_ff[1];
         ssf_pkg::REG_A_ROW_TWO:   prdata = a_coef_ff[2];
         ssf_pkg::REG_A_ROW_THREE: prdata = a_coef_ff[3];
         ssf_pkg::REG_B_COLUMN:    prdata = b_coef_ff;
         ssf_pkg::REG_C_ROW:       prdata = c_coef_ff;
         ssf_pkg::REG_D_GAIN:      prdata = ssf_pkg::CSR_DW'(d_gain_ff);
         default:                  prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Handshake: input register feeding the result register
   // ---------------------------------------------------------------------
   logic                                in_valid_ff;
   logic signed [ssf_pkg::SAMPLE_W-1:0] sample_ff;
   logic                                rsp_valid_ff;
   logic signed [ssf_pkg::SAMPLE_W-1:0] rsp_sample_out_ff;
   logic                                rsp_clipped_ff;
   logic                                advance;   // result slot free this cycle
   logic                                fire;      // request moves into result

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         sample_ff <= req_sample_in;
      end
   end

   // ---------------------------------------------------------------------
   // Datapath: one pass from state and sample to output and next state
   // ---------------------------------------------------------------------
   function automatic logic signed [PROD_W-1:0] coef_by_state(
      input logic signed [ssf_pkg::COEF_W-1:0]  coef,
      input logic signed [ssf_pkg::STATE_W-1:0] value
   );
      coef_by_state = coef * value;
   endfunction

   function automatic logic signed [2*ssf_pkg::COEF_W-1:0] coef_by_sample(
      input logic signed [ssf_pkg::COEF_W-1:0]   coef,
      input logic signed [ssf_pkg::SAMPLE_W-1:0] value
   );
      coef_by_sample = coef * value;
   endfunction

   logic [STATE_ORDER-1:0][ssf_pkg::STATE_W-1:0] state_ff;
   logic [STATE_ORDER-1:0][ssf_pkg::STATE_W-1:0] state_in;
   logic signed [ACC_W-1:0]                      y_acc;
   logic signed [RND_W-1:0]                      y_rnd;
   logic signed [ACC_W-1:0]                      st_acc [STATE_ORDER];
   logic signed [RND_W-1:0]                      st_rnd [STATE_ORDER];
   logic signed [ssf_pkg::SAMPLE_W-1:0]          rsp_sample_out_in;
   logic                                         rsp_clipped_in;

   always_comb begin
      rsp_clipped_in = 1'b0;

      // output from the current state
      y_acc = ACC_W'(coef_by_sample(d_gain_ff, sample_ff));
      for (int j = 0; j < STATE_ORDER; j++) begin
         y_acc = y_acc + ACC_W'(coef_by_state(c_coef_ff[j], state_ff[j]));
      end
      // round half up: add half an LSB, then floor
      y_rnd = RND_W'((y_acc + ROUND_HALF) >>> ssf_pkg::FRAC_W);
      if (y_rnd > OUT_MAX) begin
         rsp_sample_out_in = ssf_pkg::SAMPLE_W'(OUT_MAX);
         rsp_clipped_in    = 1'b1;
      end else if (y_rnd < OUT_MIN) begin
         rsp_sample_out_in = ssf_pkg::SAMPLE_W'(OUT_MIN);
         rsp_clipped_in    = 1'b1;
      end else begin
         rsp_sample_out_in = y_rnd[ssf_pkg::SAMPLE_W-1:0];
      end

      // state update, rows are independent
      for (int i = 0; i < STATE_ORDER; i++) begin
         st_acc[i] = ACC_W'(coef_by_sample(b_coef_ff[i], sample_ff));
         for (int j = 0; j < STATE_ORDER; j++) begin
            st_acc[i] = st_acc[i] + ACC_W'(coef_by_state(a_coef_ff[i][j], state_ff[j]));
         end
         st_rnd[i] = RND_W'((st_acc[i] + ROUND_HALF) >>> ssf_pkg::FRAC_W);
         if (st_rnd[i] > ST_MAX) begin
            state_in[i]    = ssf_pkg::STATE_W'(ST_MAX);
            rsp_clipped_in = 1'b1;
         end else if (st_rnd[i] < ST_MIN) begin
            state_in[i]    = ssf_pkg::STATE_W'(ST_MIN);
            rsp_clipped_in = 1'b1;
         end else begin
            state_in[i] = st_rnd[i][ssf_pkg::STATE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_sample_out_ff <= rsp_sample_out_in;
         rsp_clipped_ff    <= rsp_clipped_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;
   assign rsp_clipped    = rsp_clipped_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `SSF_ASSERT_NEXT(a_state_holds, clock, reset, !fire, $stable(state_ff), "state moved idle")
   `SSF_ASSERT_NOW(a_no_stall_free, clock, reset, !rsp_valid_ff, !req_stall, "stall, slot free")
   `SSF_ASSERT_NEXT(a_fire_gives_rsp, clock, reset, fire, rsp_valid_ff, "request lost")

endmodule
